// ===== hw/rtl/mwpf_pkg.sv =====
// shared types and constants for the window predictor fitness block
// transaction structs, cell control bundle, status codes and divider widths
// no dependencies
package mwpf_pkg;

  typedef struct packed {
    logic               func;
    logic [7:0]         weight_index;
    logic signed [15:0] weight_value;
    logic signed [15:0] sample;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] prediction;
    logic [15:0]        abs_error;
    logic               prediction_valid;
    logic               run_done;
    logic [31:0]        fitness;
    logic [1:0]         fitness_status;
  } out_item_t;

  typedef struct packed {
    logic               wr_en;
    logic [7:0]         wr_idx;
    logic signed [15:0] wr_data;
    logic               acc_load;
    logic               acc_en;
    logic               oprod_en;
  } cell_ctrl_t;

  localparam logic FUNC_WEIGHT = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_NONE = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  localparam int EPS_W = 16;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd168;

  localparam int ERR_W = 48;
  localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

  localparam int DVD_W = 60;
  localparam int DVS_W = 61;
  localparam logic [DVD_W-1:0] FIT_DVD = DVD_W'(64'd1 << 39);
  localparam logic [DVS_W-1:0] FIT_SAT_DEN = DVS_W'(129);

endpackage

// ===== hw/rtl/mwpf_cell.sv =====
// one hidden unit of the predictor chain: weight store, tap mac, relu,
// output weight product and one stage of the output sum chain
// depends on mwpf_pkg
module mwpf_cell #(
  parameter int WINDOW  = 8,
  parameter int HIDDEN  = 16,
  parameter int CELL_ID = 0,
  parameter int SUM_W   = 58
) (
  input  logic                                              clk,
  input  mwpf_pkg::cell_ctrl_t                              ctrl,
  input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0]    rd_idx,
  input  logic signed [15:0]                                tap,
  input  logic signed [SUM_W-1:0]                           sum_in,
  output logic signed [SUM_W-1:0]                           sum_out
);

  localparam int TAP_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int ACC_W = 33 + $clog2(WINDOW + 1);
  localparam int OP_W  = ACC_W + 16;
  localparam logic [12:0] W_BASE = 13'(CELL_ID * WINDOW);
  localparam logic [12:0] W_END  = 13'((CELL_ID + 1) * WINDOW);
  localparam logic [12:0] B_IDX  = 13'(WINDOW * HIDDEN + CELL_ID);
  localparam logic [12:0] O_IDX  = 13'(WINDOW * HIDDEN + HIDDEN + CELL_ID);

  logic signed [15:0]      hw [WINDOW];
  logic signed [15:0]      w_q;
  logic signed [15:0]      bias;
  logic signed [15:0]      ow;
  logic signed [31:0]      prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] relu_v;
  logic signed [OP_W-1:0]  oprod;
  logic [12:0]             idx;
  logic [12:0]             rel;

  assign idx    = {5'd0, ctrl.wr_idx};
  assign rel    = idx - W_BASE;
  assign relu_v = acc[ACC_W-1] ? '0 : acc;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en && idx >= W_BASE && idx < W_END) begin
      hw[rel[TAP_W-1:0]] <= ctrl.wr_data;
    end
    if (ctrl.wr_en && idx == B_IDX) begin
      bias <= ctrl.wr_data;
    end
    if (ctrl.wr_en && idx == O_IDX) begin
      ow <= ctrl.wr_data;
    end
    w_q  <= hw[rd_idx];
    prod <= 32'(tap) * 32'(w_q);
    if (ctrl.acc_load) begin
      acc <= ACC_W'(bias) <<< 12;
    end else if (ctrl.acc_en) begin
      acc <= acc + ACC_W'(prod);
    end
    if (ctrl.oprod_en) begin
      oprod <= OP_W'(relu_v) * OP_W'(ow);
    end
    sum_out <= sum_in + SUM_W'(oprod);
  end

endmodule

// ===== hw/rtl/mwpf_div.sv =====
// restoring divider, one quotient bit per cycle, shared by mean and fitness
// depends on mwpf_pkg
module mwpf_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [mwpf_pkg::DVD_W-1:0]      dividend,
  input  logic [mwpf_pkg::DVS_W-1:0]      divisor,
  output logic                            busy,
  output logic [mwpf_pkg::DVD_W-1:0]      quotient
);

  localparam int CW = $clog2(mwpf_pkg::DVD_W + 1);

  logic [CW-1:0]                 cnt;
  logic [mwpf_pkg::DVS_W:0]      rem;
  logic [mwpf_pkg::DVS_W:0]      r2;
  logic [mwpf_pkg::DVD_W-1:0]    q;
  logic [mwpf_pkg::DVS_W-1:0]    dv;
  logic                          ge;

  assign r2       = {rem[mwpf_pkg::DVS_W-1:0], q[mwpf_pkg::DVD_W-1]};
  assign ge       = r2 >= {1'b0, dv};
  assign busy     = cnt != '0;
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(mwpf_pkg::DVD_W);
      rem <= '0;
      q   <= dividend;
      dv  <= divisor;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      rem <= ge ? (r2 - {1'b0, dv}) : r2;
      q   <= {q[mwpf_pkg::DVD_W-2:0], ge};
    end
  end

endmodule

// ===== hw/rtl/mlp_window_predictor_fitness_top.sv =====
// A weight transaction (func 0) is taken while idle and writes one word of
// the network. A sample transaction that gets a prediction forms its WINDOW
// tap products in every hidden cell at once, then the output sum ripples down
// the cell chain, then rounding and error update follow. A sample marked last
// adds up to two 60-step divisions (mean error, then fitness) in the shared
// divider. One sample is in flight at a time; the input is stalled until its
// result sits in the output register, which holds it while the next
// transaction is taken. Weight stores read as garbage until written.
module mlp_window_predictor_fitness_top #(
  parameter int WINDOW      = 8,
  parameter int HIDDEN      = 16,
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mwpf_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mwpf_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int ACC_W = 33 + $clog2(WINDOW + 1);
  localparam int SUM_W = ACC_W + 16 + $clog2(HIDDEN + 1) + 1;
  localparam int SEQ_W = $clog2(WINDOW + HIDDEN + 3);
  localparam int TAP_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [SEQ_W-1:0] MAC_END = SEQ_W'(WINDOW + HIDDEN + 2);
  localparam logic [12:0] OB_IDX = 13'(WINDOW * HIDDEN + 2 * HIDDEN);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MAC  = 4'd1;
  localparam logic [3:0] ST_RND  = 4'd2;
  localparam logic [3:0] ST_ERR  = 4'd3;
  localparam logic [3:0] ST_FIN  = 4'd4;
  localparam logic [3:0] ST_DIV1 = 4'd5;
  localparam logic [3:0] ST_DEN  = 4'd6;
  localparam logic [3:0] ST_DIV2 = 4'd7;
  localparam logic [3:0] ST_EMIT = 4'd8;

  logic [3:0]                       state;
  logic [SEQ_W-1:0]                 seq;
  logic signed [15:0]               smp;
  logic                             last_r;
  logic                             use_r;
  mwpf_pkg::out_item_t              res;
  logic [mwpf_pkg::EPS_W-1:0]       eps;
  logic signed [15:0]               win [WINDOW];
  logic signed [15:0]               tap_q;
  logic [CNT_W-1:0]                 count;
  logic [mwpf_pkg::ERR_W-1:0]       err_sum;
  logic signed [15:0]               obias;
  logic                             sat_flag;
  logic                             div_start;
  logic [mwpf_pkg::DVD_W-1:0]       div_a;
  logic [mwpf_pkg::DVS_W-1:0]       div_b;
  logic                             div_busy;
  logic [mwpf_pkg::DVD_W-1:0]       div_q;
  logic [mwpf_pkg::DVS_W-1:0]       den;
  logic                             accept;
  logic                             wr_acc;
  logic                             can_use;
  logic                             can_pred;
  mwpf_pkg::cell_ctrl_t             ctrl;
  logic signed [SUM_W-1:0]          chain [HIDDEN+1];
  logic signed [SUM_W-1:0]          rsum;
  logic signed [SUM_W-1:0]          rq;
  logic signed [15:0]               pred_sat;
  logic signed [16:0]               diff;
  logic [15:0]                      aerr;
  logic [mwpf_pkg::ERR_W:0]         esum;
  logic [CNT_W-1:0]                 n_pred;

  assign in_stall  = state != ST_IDLE;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign wr_acc    = accept && in_data.func == mwpf_pkg::FUNC_WEIGHT;
  assign can_use   = 32'(count) < MAX_SAMPLES;
  assign can_pred  = can_use && 32'(count) >= WINDOW;

  always_comb begin
    ctrl.wr_en    = wr_acc;
    ctrl.wr_idx   = in_data.weight_index;
    ctrl.wr_data  = in_data.weight_value;
    ctrl.acc_load = state == ST_MAC && seq == '0;
    ctrl.acc_en   = state == ST_MAC && seq >= SEQ_W'(2) && seq <= SEQ_W'(WINDOW + 1);
    ctrl.oprod_en = state == ST_MAC && seq == SEQ_W'(WINDOW + 2);
  end

  assign chain[0] = SUM_W'(obias) <<< 24;

  for (genvar j = 0; j < HIDDEN; j++) begin : g_cell
    mwpf_cell #(
      .WINDOW (WINDOW),
      .HIDDEN (HIDDEN),
      .CELL_ID(j),
      .SUM_W  (SUM_W)
    ) u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .rd_idx (seq[TAP_W-1:0]),
      .tap    (tap_q),
      .sum_in (chain[j]),
      .sum_out(chain[j+1])
    );
  end

  mwpf_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_a),
    .divisor (div_b),
    .busy    (div_busy),
    .quotient(div_q)
  );

  always_comb begin
    rsum = chain[HIDDEN] + (SUM_W'(1) <<< 23);
    rq   = rsum >>> 24;
    if (rq > SUM_W'(32767)) begin
      pred_sat = 16'sd32767;
    end else if (rq < SUM_W'(-32768)) begin
      pred_sat = -16'sd32768;
    end else begin
      pred_sat = rq[15:0];
    end
    diff   = 17'(res.prediction) - 17'(smp);
    aerr   = diff[16] ? 16'(-diff) : diff[15:0];
    esum   = {1'b0, err_sum} + (mwpf_pkg::ERR_W + 1)'(aerr);
    n_pred = (32'(count) > WINDOW) ? CNT_W'(32'(count) - WINDOW) : '0;
  end

  always_ff @(posedge clk) begin
    if (wr_acc && {5'd0, in_data.weight_index} == OB_IDX) begin
      obias <= in_data.weight_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seq       <= '0;
      count     <= '0;
      err_sum   <= '0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      eps       <= mwpf_pkg::EPS_RESET;
      for (int k = 0; k < WINDOW; k++) begin
        win[k] <= '0;
      end
    end else begin
      div_start <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        eps <= cfg_data;
      end
      if (out_valid && !out_stall && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && in_data.func == mwpf_pkg::FUNC_SAMPLE) begin
            smp    <= in_data.sample;
            last_r <= in_data.last;
            use_r  <= can_use;
            res    <= mwpf_pkg::out_item_t'({33'd0, in_data.last, 34'd0});
            seq    <= '0;
            state  <= can_pred ? ST_MAC : ST_ERR;
          end
        end
        ST_MAC: begin
          seq   <= seq + 1'b1;
          tap_q <= win[0];
          if (seq < SEQ_W'(WINDOW)) begin
            for (int k = 0; k < WINDOW - 1; k++) begin
              win[k] <= win[k+1];
            end
            win[WINDOW-1] <= win[0];
          end
          if (seq == MAC_END) begin
            state <= ST_RND;
          end
        end
        ST_RND: begin
          res.prediction       <= pred_sat;
          res.prediction_valid <= 1'b1;
          state                <= ST_ERR;
        end
        ST_ERR: begin
          if (res.prediction_valid) begin
            res.abs_error <= aerr;
            err_sum       <= esum[mwpf_pkg::ERR_W] ? mwpf_pkg::ERR_MAX
                                                   : esum[mwpf_pkg::ERR_W-1:0];
          end
          if (use_r) begin
            for (int k = 0; k < WINDOW - 1; k++) begin
              win[k] <= win[k+1];
            end
            win[WINDOW-1] <= smp;
            count         <= count + 1'b1;
          end
          state <= last_r ? ST_FIN : ST_EMIT;
        end
        ST_FIN: begin
          sat_flag <= err_sum == mwpf_pkg::ERR_MAX;
          count    <= '0;
          err_sum  <= '0;
          for (int k = 0; k < WINDOW; k++) begin
            win[k] <= '0;
          end
          if (n_pred == '0) begin
            res.fitness_status <= mwpf_pkg::STAT_NONE;
            state              <= ST_EMIT;
          end else begin
            div_a     <= {err_sum, 12'd0};
            div_b     <= mwpf_pkg::DVS_W'(n_pred);
            div_start <= 1'b1;
            state     <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (!div_start && !div_busy) begin
            den   <= mwpf_pkg::DVS_W'(div_q) + mwpf_pkg::DVS_W'(eps);
            state <= ST_DEN;
          end
        end
        ST_DEN: begin
          if (den < mwpf_pkg::FIT_SAT_DEN) begin
            res.fitness        <= '1;
            res.fitness_status <= mwpf_pkg::STAT_SAT;
            state              <= ST_EMIT;
          end else begin
            div_a     <= mwpf_pkg::FIT_DVD;
            div_b     <= den;
            div_start <= 1'b1;
            state     <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (!div_start && !div_busy) begin
            res.fitness        <= div_q[31:0];
            res.fitness_status <= sat_flag ? mwpf_pkg::STAT_SAT : mwpf_pkg::STAT_OK;
            state              <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= MAX_SAMPLES)
    else $error("sample count past limit");

  a_no_fit_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.run_done |->
      out_data.fitness == '0 && out_data.fitness_status == mwpf_pkg::STAT_OK)
    else $error("fitness reported before run end");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == ST_DIV1 || state == ST_DIV2)
    else $error("divider busy outside divide states");
`endif

endmodule
